### hw/rtl/integer_matrix_multiply_defines.svh
// ----------------------------------------------------------------------------
// integer matrix multiply assertion macros
// shared property forms, clocked on clk and disabled while rst_n is low
// ----------------------------------------------------------------------------
`ifndef INTEGER_MATRIX_MULTIPLY_DEFINES_SVH
`define INTEGER_MATRIX_MULTIPLY_DEFINES_SVH

// expression holds at every edge out of reset
`define IMM_ASSERT_ALWAYS(label, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// consequent holds in the same cycle as the antecedent
`define IMM_ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

### hw/rtl/imm_pkg.sv
// ----------------------------------------------------------------------------
// imm_pkg
// types and constants shared by the integer matrix multiply block
// ----------------------------------------------------------------------------
package imm_pkg;

    localparam int MAX_DIM     = 8;
    localparam int DATA_WIDTH  = 32;
    localparam int STORE_DEPTH = MAX_DIM * MAX_DIM;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);
    localparam int FILL_W      = ADDR_W + 1;
    localparam int DIM_W       = 4;
    localparam int IDX_W       = 3;
    localparam int REG_IDX_W   = 2;

    localparam int CMD_DEPTH   = 4;
    localparam int RES_DEPTH   = 4;
    localparam int QPTR_W      = 2;
    localparam int QCNT_W      = 3;

    localparam logic [DIM_W-1:0] DIM_RESET = 4'd2;

    // input item modes
    localparam logic [1:0] MODE_LOAD_A = 2'd0;
    localparam logic [1:0] MODE_LOAD_B = 2'd1;
    localparam logic [1:0] MODE_START  = 2'd2;
    localparam logic [1:0] MODE_NOP    = 2'd3;

    // configuration register indexes
    localparam logic [REG_IDX_W-1:0] REG_ROWS_A = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_COLS_A = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_ROWS_B = 2'd2;
    localparam logic [REG_IDX_W-1:0] REG_COLS_B = 2'd3;

    typedef struct packed {
        logic [1:0]         mode;
        logic signed [31:0] value;
    } item_t;

    typedef struct packed {
        logic signed [31:0] product;
        logic [2:0]         row;
        logic [2:0]         col;
        logic               last;
        logic               error;
    } res_t;

    typedef enum logic [1:0] {
        OP_LOAD_A,
        OP_LOAD_B,
        OP_START
    } cmd_op_t;

    typedef struct packed {
        cmd_op_t                 op;
        logic [ADDR_W-1:0]       addr;
        logic [DATA_WIDTH-1:0]   value;
        logic [IDX_W-1:0]        ra_m1;
        logic [IDX_W-1:0]        ca_m1;
        logic [IDX_W-1:0]        cb_m1;
        logic                    mismatch;
    } cmd_t;

    typedef struct packed {
        logic              full;
        logic [QCNT_W-1:0] count;
    } res_stat_t;

endpackage

### hw/rtl/imm_front.sv
// ----------------------------------------------------------------------------
// imm_front
// accepts items, holds dimensions and load counters, issues commands
// ----------------------------------------------------------------------------
module imm_front (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               push,
    input  imm_pkg::item_t                     item,
    input  logic                               cmd_full,
    output logic                               cmd_push,
    output imm_pkg::cmd_t                      cmd,
    input  logic                               wr_en,
    input  logic [imm_pkg::REG_IDX_W-1:0]      wr_index,
    input  logic [imm_pkg::DIM_W-1:0]          wr_data
);
    import imm_pkg::*;

    logic [DIM_W-1:0]  rows_a_reg, cols_a_reg, rows_b_reg, cols_b_reg;
    logic [DIM_W-1:0]  rows_a_next, cols_a_next, rows_b_next, cols_b_next;
    logic [FILL_W-1:0] a_fill_reg, b_fill_reg;
    logic [FILL_W-1:0] a_fill_next, b_fill_next;
    logic              accept;
    logic [DIM_W-1:0]  ra_c, ca_c, rb_c, cb_c;

    function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] d);
        logic [DIM_W-1:0] r;
        if (d == '0)
            r = DIM_W'(1);
        else if (d > DIM_W'(MAX_DIM))
            r = DIM_W'(MAX_DIM);
        else
            r = d;
        return r;
    endfunction

    assign accept = push && !cmd_full;
    assign ra_c   = clamp_dim(rows_a_reg);
    assign ca_c   = clamp_dim(cols_a_reg);
    assign rb_c   = clamp_dim(rows_b_reg);
    assign cb_c   = clamp_dim(cols_b_reg);

    always_comb
    begin
        rows_a_next = rows_a_reg;
        cols_a_next = cols_a_reg;
        rows_b_next = rows_b_reg;
        cols_b_next = cols_b_reg;
        if (wr_en)
        begin
            unique case (wr_index)
                REG_ROWS_A: rows_a_next = wr_data;
                REG_COLS_A: cols_a_next = wr_data;
                REG_ROWS_B: rows_b_next = wr_data;
                REG_COLS_B: cols_b_next = wr_data;
            endcase
        end
    end

    always_comb
    begin
        a_fill_next  = a_fill_reg;
        b_fill_next  = b_fill_reg;
        cmd_push     = 1'b0;
        cmd.op       = OP_LOAD_A;
        cmd.addr     = '0;
        cmd.value    = item.value;
        cmd.ra_m1    = IDX_W'(ra_c - DIM_W'(1));
        cmd.ca_m1    = IDX_W'(ca_c - DIM_W'(1));
        cmd.cb_m1    = IDX_W'(cb_c - DIM_W'(1));
        cmd.mismatch = (ca_c != rb_c);
        if (accept)
        begin
            unique case (item.mode)
                MODE_LOAD_A:
                begin
                    // a full store drops the load
                    if (a_fill_reg < FILL_W'(STORE_DEPTH))
                    begin
                        cmd_push    = 1'b1;
                        cmd.op      = OP_LOAD_A;
                        cmd.addr    = a_fill_reg[ADDR_W-1:0];
                        a_fill_next = a_fill_reg + FILL_W'(1);
                    end
                end
                MODE_LOAD_B:
                begin
                    if (b_fill_reg < FILL_W'(STORE_DEPTH))
                    begin
                        cmd_push    = 1'b1;
                        cmd.op      = OP_LOAD_B;
                        cmd.addr    = b_fill_reg[ADDR_W-1:0];
                        b_fill_next = b_fill_reg + FILL_W'(1);
                    end
                end
                MODE_START:
                begin
                    cmd_push    = 1'b1;
                    cmd.op      = OP_START;
                    a_fill_next = '0;
                    b_fill_next = '0;
                end
                MODE_NOP:
                begin
                    cmd_push = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rows_a_reg <= DIM_RESET;
            cols_a_reg <= DIM_RESET;
            rows_b_reg <= DIM_RESET;
            cols_b_reg <= DIM_RESET;
            a_fill_reg <= '0;
            b_fill_reg <= '0;
        end
        else
        begin
            rows_a_reg <= rows_a_next;
            cols_a_reg <= cols_a_next;
            rows_b_reg <= rows_b_next;
            cols_b_reg <= cols_b_next;
            a_fill_reg <= a_fill_next;
            b_fill_reg <= b_fill_next;
        end
    end

endmodule

### hw/rtl/imm_cmd_queue.sv
// ----------------------------------------------------------------------------
// imm_cmd_queue
// short command queue between the front and the back
// ----------------------------------------------------------------------------
module imm_cmd_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  imm_pkg::cmd_t din,
    input  logic          pop,
    output imm_pkg::cmd_t dout,
    output logic          empty,
    output logic          full
);
    import imm_pkg::*;

    cmd_t              entries_reg [CMD_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;
    logic              do_push, do_pop;

    assign empty   = (count_reg == '0);
    assign full    = (count_reg == QCNT_W'(CMD_DEPTH));
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign dout    = entries_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + QPTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + QPTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg + QCNT_W'(do_push) - QCNT_W'(do_pop);
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            entries_reg[wr_ptr_reg] <= din;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

### hw/rtl/imm_res_queue.sv
// ----------------------------------------------------------------------------
// imm_res_queue
// result queue that decouples the multiply pipeline from the receiver
// ----------------------------------------------------------------------------
module imm_res_queue (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  imm_pkg::res_t      din,
    input  logic               pop,
    output imm_pkg::res_t      dout,
    output logic               empty,
    output imm_pkg::res_stat_t stat
);
    import imm_pkg::*;

    res_t              entries_reg [RES_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;
    logic              do_push, do_pop;

    assign empty      = (count_reg == '0);
    assign stat.full  = (count_reg == QCNT_W'(RES_DEPTH));
    assign stat.count = count_reg;
    assign do_push    = push && !stat.full;
    assign do_pop     = pop && !empty;
    assign dout       = entries_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + QPTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + QPTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg + QCNT_W'(do_push) - QCNT_W'(do_pop);
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            entries_reg[wr_ptr_reg] <= din;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

### hw/rtl/imm_back.sv
// ----------------------------------------------------------------------------
// imm_back
// matrix stores and the multiply-accumulate pipeline that executes commands
// ----------------------------------------------------------------------------
`include "integer_matrix_multiply_defines.svh"

module imm_back (
    input  logic               clk,
    input  logic               rst_n,
    input  imm_pkg::cmd_t      cmd,
    input  logic               cmd_empty,
    output logic               cmd_pop,
    input  imm_pkg::res_stat_t res_stat,
    output logic               res_push,
    output imm_pkg::res_t      res
);
    import imm_pkg::*;

    typedef enum logic {
        ST_IDLE,
        ST_RUN
    } state_t;

    typedef struct packed {
        logic             valid;
        logic             first;
        logic             lastk;
        logic [IDX_W-1:0] row;
        logic [IDX_W-1:0] col;
        logic             last;
    } pipe_ctl_t;

    state_t            state_reg, state_next;
    logic [IDX_W-1:0]  i_reg, i_next, j_reg, j_next, k_reg, k_next;
    logic [IDX_W-1:0]  ra_m1_reg, ra_m1_next, ca_m1_reg, ca_m1_next;
    logic [IDX_W-1:0]  cb_m1_reg, cb_m1_next;
    logic [QCNT_W-1:0] reserved_reg, reserved_next;
    pipe_ctl_t         s1_reg, s1_next, s2_reg;

    logic [DATA_WIDTH-1:0] a_mem [STORE_DEPTH];
    logic [DATA_WIDTH-1:0] b_mem [STORE_DEPTH];
    logic [DATA_WIDTH-1:0] a_rd_reg, b_rd_reg, prod_reg, acc_reg;
    logic [DATA_WIDTH-1:0] mul_lo, acc_sum;

    logic              a_we, b_we, err_push, pipe_push, issue, credit_ok;
    logic              k_end, j_end, i_end, pipe_busy;
    logic [QCNT_W:0]   credit_used;
    logic [DIM_W-1:0]  ca_dim, cb_dim;
    logic [ADDR_W-1:0] a_addr, b_addr;

    assign ca_dim = {1'b0, ca_m1_reg} + DIM_W'(1);
    assign cb_dim = {1'b0, cb_m1_reg} + DIM_W'(1);
    assign a_addr = ADDR_W'(i_reg) * ADDR_W'(ca_dim) + ADDR_W'(k_reg);
    assign b_addr = ADDR_W'(k_reg) * ADDR_W'(cb_dim) + ADDR_W'(j_reg);

    assign k_end = (k_reg == ca_m1_reg);
    assign j_end = (j_reg == cb_m1_reg);
    assign i_end = (i_reg == ra_m1_reg);

    // an element may start only when its result has a guaranteed queue slot
    assign credit_used = {1'b0, res_stat.count} + {1'b0, reserved_reg};
    assign credit_ok   = credit_used < (QCNT_W+1)'(RES_DEPTH);
    assign pipe_busy   = s1_reg.valid || s2_reg.valid;

    assign pipe_push = s2_reg.valid && s2_reg.lastk;
    assign mul_lo    = a_rd_reg * b_rd_reg;
    assign acc_sum   = s2_reg.first ? prod_reg : acc_reg + prod_reg;

    always_comb
    begin
        state_next = state_reg;
        i_next     = i_reg;
        j_next     = j_reg;
        k_next     = k_reg;
        ra_m1_next = ra_m1_reg;
        ca_m1_next = ca_m1_reg;
        cb_m1_next = cb_m1_reg;
        cmd_pop    = 1'b0;
        a_we       = 1'b0;
        b_we       = 1'b0;
        err_push   = 1'b0;
        issue      = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (!cmd_empty)
                begin
                    unique case (cmd.op)
                        OP_LOAD_A:
                        begin
                            a_we    = 1'b1;
                            cmd_pop = 1'b1;
                        end
                        OP_LOAD_B:
                        begin
                            b_we    = 1'b1;
                            cmd_pop = 1'b1;
                        end
                        OP_START:
                        begin
                            if (cmd.mismatch)
                            begin
                                // wait until earlier results have left the pipeline
                                if (reserved_reg == '0 && !res_stat.full)
                                begin
                                    err_push = 1'b1;
                                    cmd_pop  = 1'b1;
                                end
                            end
                            else
                            begin
                                cmd_pop    = 1'b1;
                                ra_m1_next = cmd.ra_m1;
                                ca_m1_next = cmd.ca_m1;
                                cb_m1_next = cmd.cb_m1;
                                i_next     = '0;
                                j_next     = '0;
                                k_next     = '0;
                                state_next = ST_RUN;
                            end
                        end
                        default:
                        begin
                            cmd_pop = 1'b1;
                        end
                    endcase
                end
            end
            ST_RUN:
            begin
                issue = (k_reg != '0) || credit_ok;
                if (issue)
                begin
                    if (!k_end)
                        k_next = k_reg + IDX_W'(1);
                    else
                    begin
                        k_next = '0;
                        if (!j_end)
                            j_next = j_reg + IDX_W'(1);
                        else
                        begin
                            j_next = '0;
                            i_next = i_reg + IDX_W'(1);
                            if (i_end)
                                state_next = ST_IDLE;
                        end
                    end
                end
            end
        endcase
    end

    always_comb
    begin
        s1_next.valid = issue;
        s1_next.first = (k_reg == '0);
        s1_next.lastk = k_end;
        s1_next.row   = i_reg;
        s1_next.col   = j_reg;
        s1_next.last  = i_end && j_end;
        reserved_next = reserved_reg + QCNT_W'(issue && (k_reg == '0))
                        - QCNT_W'(pipe_push);
    end

    always_comb
    begin
        res_push = pipe_push || err_push;
        if (err_push)
        begin
            res.product = '0;
            res.row     = '0;
            res.col     = '0;
            res.last    = 1'b1;
            res.error   = 1'b1;
        end
        else
        begin
            res.product = acc_sum;
            res.row     = s2_reg.row;
            res.col     = s2_reg.col;
            res.last    = s2_reg.last;
            res.error   = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (a_we)
            a_mem[cmd.addr] <= cmd.value;
        if (b_we)
            b_mem[cmd.addr] <= cmd.value;
        if (issue)
        begin
            a_rd_reg <= a_mem[a_addr];
            b_rd_reg <= b_mem[b_addr];
        end
        if (s1_reg.valid)
            prod_reg <= mul_lo;
        if (s2_reg.valid)
            acc_reg <= acc_sum;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            i_reg        <= '0;
            j_reg        <= '0;
            k_reg        <= '0;
            ra_m1_reg    <= '0;
            ca_m1_reg    <= '0;
            cb_m1_reg    <= '0;
            reserved_reg <= '0;
            s1_reg       <= '0;
            s2_reg       <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            i_reg        <= i_next;
            j_reg        <= j_next;
            k_reg        <= k_next;
            ra_m1_reg    <= ra_m1_next;
            ca_m1_reg    <= ca_m1_next;
            cb_m1_reg    <= cb_m1_next;
            reserved_reg <= reserved_next;
            s1_reg       <= s1_next;
            s2_reg       <= s1_reg;
        end
    end

    `IMM_ASSERT_IMPLY(a_push_has_room, res_push, !res_stat.full, "result pushed into a full queue")
    `IMM_ASSERT_ALWAYS(a_credit_bound, credit_used <= (QCNT_W+1)'(RES_DEPTH), "slots overcommitted")
    `IMM_ASSERT_IMPLY(a_push_reserved, pipe_push, reserved_reg != '0, "result slot not reserved")
    `IMM_ASSERT_IMPLY(a_err_drained, err_push, !pipe_busy, "error item overtakes running results")

endmodule

### hw/rtl/integer_matrix_multiply.sv
// ----------------------------------------------------------------------------
// integer_matrix_multiply
// loads two integer matrices and streams out their product in row-major order
// ----------------------------------------------------------------------------
// usage:
//   input channel (push/full, item): mode 0 loads the next A element, mode 1 the
//   next B element, mode 2 starts a multiply and rewinds both load counters,
//   mode 3 does nothing. an item is taken when push is high and full is low.
//   result channel (empty/pop, result): one item per element of C, last marks the
//   final one; a mismatched inner dimension gives a single error item. the user
//   writes dimensions on wr_en/wr_index/wr_data while the block is idle (unchecked).
// timing:
//   load items are taken one per cycle while full is low and pass through the
//   command queue to their store, which the back end writes only while idle.
//   a start runs rows_a * cols_b * cols_a multiply-accumulates, one per cycle
//   unless no result slot is free, through the single multiplier and one read
//   port on each store, and each result passes the operand and product registers.
// reset: dimensions go to 2, load counters to 0, both queues empty; store
//   contents are undefined until loaded.
// stall: a 4-deep result queue fills, the back end stops issuing, then the
//   4-deep command queue fills and full rises.
// ----------------------------------------------------------------------------
module integer_matrix_multiply (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          push,
    output logic                          full,
    input  imm_pkg::item_t                item,
    output logic                          empty,
    input  logic                          pop,
    output imm_pkg::res_t                 result,
    input  logic                          wr_en,
    input  logic [imm_pkg::REG_IDX_W-1:0] wr_index,
    input  logic [imm_pkg::DIM_W-1:0]     wr_data
);
    import imm_pkg::*;

    cmd_t      front_cmd, queue_cmd;
    logic      front_push, cmd_full, cmd_empty, cmd_pop;
    res_t      back_res;
    logic      back_push;
    res_stat_t res_stat;

    assign full = cmd_full;

    imm_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .item     (item),
        .cmd_full (cmd_full),
        .cmd_push (front_push),
        .cmd      (front_cmd),
        .wr_en    (wr_en),
        .wr_index (wr_index),
        .wr_data  (wr_data)
    );

    imm_cmd_queue u_cmd_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (front_push),
        .din   (front_cmd),
        .pop   (cmd_pop),
        .dout  (queue_cmd),
        .empty (cmd_empty),
        .full  (cmd_full)
    );

    imm_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (queue_cmd),
        .cmd_empty (cmd_empty),
        .cmd_pop   (cmd_pop),
        .res_stat  (res_stat),
        .res_push  (back_push),
        .res       (back_res)
    );

    imm_res_queue u_res_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (back_push),
        .din   (back_res),
        .pop   (pop),
        .dout  (result),
        .empty (empty),
        .stat  (res_stat)
    );

endmodule
